// ===== rtl/svs_pkg.sv =====
package svs_pkg;

    localparam int unsigned MvW     = 16;
    localparam int unsigned CfgIdxW = 4;

    localparam logic [MvW:0]   HYST_MARGIN_MV = 17'd100;
    localparam logic [MvW-1:0] START_TICKS    = 16'd150;

    typedef enum logic [1:0] {
        ZONE_NORMAL = 2'd0,
        ZONE_HIGH   = 2'd1,
        ZONE_LOW    = 2'd2
    } t_zone;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COMM_HIGH_MV         = 4'd0,
        REG_COMM_LOW_MV          = 4'd1,
        REG_DIAG_HIGH_MV         = 4'd2,
        REG_DIAG_HIGH_RECOVER_MV = 4'd3,
        REG_DIAG_LOW_MV          = 4'd4,
        REG_DIAG_LOW_RECOVER_MV  = 4'd5,
        REG_RECOVER_TICKS        = 4'd6,
        REG_FAULT_TICKS          = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [MvW-1:0] comm_high_mv;
        logic [MvW-1:0] comm_low_mv;
        logic [MvW-1:0] diag_high_mv;
        logic [MvW-1:0] diag_high_recover_mv;
        logic [MvW-1:0] diag_low_mv;
        logic [MvW-1:0] diag_low_recover_mv;
        logic [MvW-1:0] recover_ticks;
        logic [MvW-1:0] fault_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        comm_high_mv:         16'd18000,
        comm_low_mv:          16'd8000,
        diag_high_mv:         16'd16000,
        diag_high_recover_mv: 16'd15000,
        diag_low_mv:          16'd9000,
        diag_low_recover_mv:  16'd10000,
        recover_ticks:        16'd200,
        fault_ticks:          16'd200
    };

    typedef struct packed {
        t_zone zone;
        logic  active;
        logic  power_on;
        logic  resume;
        logic  stop;
    } t_comm_res;

    typedef struct packed {
        t_zone zone;
        logic  high_fault;
        logic  low_fault;
    } t_diag_res;

endpackage

// ===== rtl/svs_comm.sv =====
module svs_comm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [svs_pkg::MvW-1:0]        i_voltage_mv,
    input  svs_pkg::t_cfg                  i_cfg,
    output svs_pkg::t_comm_res             o_res
);
    import svs_pkg::*;

    t_zone        r_zone, n_zone;
    logic         r_comm_on, n_comm_on;
    logic         r_powered_once, n_powered_once;
    logic         w_start, w_stop;
    logic [MvW:0] w_v, w_vm;

    assign w_v  = {1'b0, i_voltage_mv};
    assign w_vm = w_v + HYST_MARGIN_MV;

    always_comb begin
        n_zone  = r_zone;
        w_start = 1'b0;
        w_stop  = 1'b0;
        case (r_zone)
            ZONE_NORMAL: begin
                if (w_v > ({1'b0, i_cfg.comm_high_mv} + HYST_MARGIN_MV)) begin
                    n_zone = ZONE_HIGH;
                    w_stop = 1'b1;
                end else if (w_vm < {1'b0, i_cfg.comm_low_mv}) begin
                    n_zone = ZONE_LOW;
                    w_stop = 1'b1;
                end
            end
            ZONE_HIGH: begin
                if (i_voltage_mv < i_cfg.comm_high_mv) begin
                    n_zone  = ZONE_NORMAL;
                    w_start = 1'b1;
                end else begin
                    w_stop = 1'b1;
                end
            end
            default: begin
                if (i_voltage_mv > i_cfg.comm_low_mv) begin
                    n_zone  = ZONE_NORMAL;
                    w_start = 1'b1;
                end else begin
                    w_stop = 1'b1;
                end
            end
        endcase

        n_comm_on      = r_comm_on;
        n_powered_once = r_powered_once;
        o_res.power_on = 1'b0;
        o_res.resume   = 1'b0;
        o_res.stop     = 1'b0;
        if (w_start && !r_comm_on) begin
            n_comm_on      = 1'b1;
            n_powered_once = 1'b1;
            o_res.power_on = !r_powered_once;
            o_res.resume   = r_powered_once;
        end
        if (w_stop && r_comm_on) begin
            n_comm_on  = 1'b0;
            o_res.stop = 1'b1;
        end
        o_res.zone   = n_zone;
        o_res.active = n_comm_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone         <= ZONE_LOW;
            r_comm_on      <= 1'b0;
            r_powered_once <= 1'b0;
        end else if (i_step) begin
            r_zone         <= n_zone;
            r_comm_on      <= n_comm_on;
            r_powered_once <= n_powered_once;
        end
    end

    a_on_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comm_on |-> r_powered_once)
        else $error("comm active before first power on");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_comm_on) && $stable(r_zone))
        else $error("comm state moved without a step");

endmodule

// ===== rtl/svs_diag.sv =====
module svs_diag (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [svs_pkg::MvW-1:0]        i_voltage_mv,
    input  logic                           i_reset_request,
    input  svs_pkg::t_cfg                  i_cfg,
    output svs_pkg::t_diag_res             o_res
);
    import svs_pkg::*;

    t_zone          r_zone, n_zone;
    logic [MvW-1:0] r_recover_count, n_recover_count;
    logic [MvW-1:0] r_fault_count, n_fault_count;
    logic           r_started, n_started;
    logic           r_high_fault, n_high_fault;
    logic           r_low_fault, n_low_fault;
    logic [MvW-1:0] w_limit;
    logic [MvW:0]   w_v, w_vm;

    assign w_v     = {1'b0, i_voltage_mv};
    assign w_vm    = w_v + HYST_MARGIN_MV;
    assign w_limit = r_started ? i_cfg.recover_ticks : START_TICKS;

    always_comb begin
        n_zone          = r_zone;
        n_recover_count = r_recover_count;
        n_fault_count   = r_fault_count;
        n_started       = r_started;
        n_high_fault    = r_high_fault;
        n_low_fault     = r_low_fault;
        case (r_zone)
            ZONE_NORMAL: begin
                if (i_voltage_mv > i_cfg.diag_high_mv) begin
                    n_zone          = ZONE_HIGH;
                    n_recover_count = '0;
                    n_fault_count   = '0;
                end else if (i_voltage_mv < i_cfg.diag_low_mv) begin
                    n_zone          = ZONE_LOW;
                    n_recover_count = '0;
                    n_fault_count   = '0;
                end
            end
            ZONE_HIGH: begin
                if (w_vm <= {1'b0, i_cfg.diag_high_recover_mv}) begin
                    n_fault_count = '0;
                    if (r_recover_count >= i_cfg.recover_ticks) begin
                        n_zone       = ZONE_NORMAL;
                        n_high_fault = 1'b0;
                    end else begin
                        n_recover_count = r_recover_count + 16'd1;
                    end
                end else begin
                    n_recover_count = '0;
                    if (w_v > ({1'b0, i_cfg.diag_high_mv} + HYST_MARGIN_MV)) begin
                        if (r_fault_count >= i_cfg.fault_ticks) begin
                            n_high_fault = 1'b1;
                        end else begin
                            n_fault_count = r_fault_count + 16'd1;
                        end
                    end else begin
                        n_fault_count = '0;
                    end
                end
            end
            default: begin
                if (w_v >= ({1'b0, i_cfg.diag_low_recover_mv} + HYST_MARGIN_MV)) begin
                    n_fault_count = '0;
                    if (r_recover_count >= w_limit) begin
                        n_zone      = ZONE_NORMAL;
                        n_started   = 1'b1;
                        n_low_fault = 1'b0;
                    end else begin
                        n_recover_count = r_recover_count + 16'd1;
                    end
                end else begin
                    n_recover_count = '0;
                    if (w_vm < {1'b0, i_cfg.diag_low_mv}) begin
                        if (r_fault_count >= i_cfg.fault_ticks) begin
                            n_low_fault = 1'b1;
                        end else begin
                            n_fault_count = r_fault_count + 16'd1;
                        end
                    end else begin
                        n_fault_count = '0;
                    end
                end
            end
        endcase

        if (i_reset_request && (n_zone != ZONE_NORMAL)) begin
            n_fault_count = '0;
            n_high_fault  = 1'b0;
            n_low_fault   = 1'b0;
        end

        o_res.zone       = n_zone;
        o_res.high_fault = n_high_fault;
        o_res.low_fault  = n_low_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone          <= ZONE_LOW;
            r_recover_count <= '0;
            r_fault_count   <= '0;
            r_started       <= 1'b0;
            r_high_fault    <= 1'b0;
            r_low_fault     <= 1'b0;
        end else if (i_step) begin
            r_zone          <= n_zone;
            r_recover_count <= n_recover_count;
            r_fault_count   <= n_fault_count;
            r_started       <= n_started;
            r_high_fault    <= n_high_fault;
            r_low_fault     <= n_low_fault;
        end
    end

    a_normal_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zone == ZONE_NORMAL) |-> (r_fault_count == '0))
        else $error("fault count running in normal zone");

endmodule

// ===== rtl/supply_voltage_supervisor.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata voltage_mv, tuser reset_request
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata zone, pulse and fault flags
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one sample per cycle sustained while m_axis_tready is high; the input and result
// stages are registered, and the zone machines update between the two registers
// a stalled result register holds the input stage, which then blocks s_axis
// synchronous active-low reset: zones low, flags and counters cleared, registers
// at their defaults; the config port is always ready
module supply_voltage_supervisor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] voltage_mv
    input  logic                            s_axis_tuser,  // [0] reset_request
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] comm_zone, [3:2] diag_zone, [4] comm_active, [5] power_on_pulse,
    // [6] comm_resume_pulse, [7] comm_stop_pulse, [8] high_fault, [9] low_fault
    output logic [15:0]                     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [svs_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [svs_pkg::MvW-1:0]         i_cfg_data
);
    import svs_pkg::*;

    t_cfg           r_cfg;
    logic           r_in_valid;
    logic [MvW-1:0] r_in_voltage;
    logic           r_in_req;
    logic           r_out_valid;
    logic [15:0]    r_out_data;
    logic           w_adv, w_step;
    t_comm_res      w_comm;
    t_diag_res      w_diag;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    svs_comm u_comm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_voltage_mv (r_in_voltage),
        .i_cfg        (r_cfg),
        .o_res        (w_comm)
    );

    svs_diag u_diag (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_voltage_mv    (r_in_voltage),
        .i_reset_request (r_in_req),
        .i_cfg           (r_cfg),
        .o_res           (w_diag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_COMM_HIGH_MV:         r_cfg.comm_high_mv         <= i_cfg_data;
                    REG_COMM_LOW_MV:          r_cfg.comm_low_mv          <= i_cfg_data;
                    REG_DIAG_HIGH_MV:         r_cfg.diag_high_mv         <= i_cfg_data;
                    REG_DIAG_HIGH_RECOVER_MV: r_cfg.diag_high_recover_mv <= i_cfg_data;
                    REG_DIAG_LOW_MV:          r_cfg.diag_low_mv          <= i_cfg_data;
                    REG_DIAG_LOW_RECOVER_MV:  r_cfg.diag_low_recover_mv  <= i_cfg_data;
                    REG_RECOVER_TICKS:        r_cfg.recover_ticks        <= i_cfg_data;
                    REG_FAULT_TICKS:          r_cfg.fault_ticks          <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_voltage <= s_axis_tdata;
            r_in_req     <= s_axis_tuser;
        end
        if (w_step) begin
            r_out_data <= {6'd0,
                           w_diag.low_fault, w_diag.high_fault,
                           w_comm.stop, w_comm.resume, w_comm.power_on,
                           w_comm.active, w_diag.zone, w_comm.zone};
        end
    end

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out_data[7:5]))
        else $error("more than one comm pulse in one result");

endmodule
